FILE: hw/rtl/lks_pkg.sv
// ----------------------------------------------------------------------------
// lks_pkg
// Shared types and constants of the link keepalive supervisor.
// ----------------------------------------------------------------------------
`default_nettype none

package lks_pkg;

  // Event opcodes
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_MSG   = 2'd1,
    OP_EVENT = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  // Message kinds carried by arrivals
  typedef enum logic [1:0] {
    KIND_OTHER  = 2'd0,
    KIND_BEGIN  = 2'd1,
    KIND_CHUNK  = 2'd2,
    KIND_DONE   = 2'd3
  } kind_e;

  // Result actions
  typedef enum logic [2:0] {
    ACT_NONE        = 3'd0,
    ACT_PING        = 3'd1,
    ACT_MISSED      = 3'd2,
    ACT_DISCONNECT  = 3'd3,
    ACT_CHUNK_OK    = 3'd4,
    ACT_CHUNK_BAD   = 3'd5,
    ACT_EVT_OK      = 3'd6,
    ACT_EVT_REFUSED = 3'd7
  } action_e;

  // Register indexes (byte address = 4 * index)
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PING_INTERVAL = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EVENT_WINDOW  = 2'd3;
  localparam int unsigned PADDR_W = CFG_IDX_W + 2;

  // Register reset values
  localparam logic [15:0] CHUNK_TIMEOUT_RST = 16'd3000;
  localparam logic [15:0] ACK_TIMEOUT_RST   = 16'd10000;
  localparam logic [15:0] PING_INTERVAL_RST = 16'd15000;
  localparam logic [15:0] EVENT_WINDOW_RST  = 16'd1000;

  // Burst history: default depth and reset stamp (1000 ms before time zero)
  localparam int unsigned BURST_SLOTS_DEF = 5;
  localparam logic [31:0] HISTORY_RST     = 32'hFFFF_FC18;

  // Configuration register set
  typedef struct packed {
    logic [15:0] chunk_timeout_ms;
    logic [15:0] ack_timeout_ms;
    logic [15:0] ping_interval_ms;
    logic [15:0] event_window_ms;
  } cfg_t;

endpackage

`default_nettype wire

FILE: hw/rtl/lks_ifs.sv
// ----------------------------------------------------------------------------
// lks_ifs
// Valid/ready channels of the supervisor: event words in, result words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface lks_evt_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] now_ms;
  logic [1:0]  msg_kind;
  logic        crc_ok;
  logic [15:0] next_chunk;

  modport source (output valid, op, now_ms, msg_kind, crc_ok, next_chunk,
                  input ready);
  modport sink   (input valid, op, now_ms, msg_kind, crc_ok, next_chunk,
                  output ready);
endinterface

interface lks_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [15:0] missed_index;

  modport source (output valid, action, missed_index, input ready);
  modport sink   (input valid, action, missed_index, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/link_keepalive_supervisor.sv
// ----------------------------------------------------------------------------
// link_keepalive_supervisor
// Keepalive, firmware-update chunk and event-rate supervisor for one link.
// ----------------------------------------------------------------------------
// Each event word yields exactly one result word. Words flow through an input
// register and a result register with combinational decision logic between
// them, so the block takes one word per clock while the result side does not
// hold it back. A result word is presented from the result register once its
// event has left the input register; the only stall is back-pressure from the
// result side. Timers compare wrapping 32-bit gaps (now_ms minus the stored
// time) strictly against the 16-bit registers. Write registers over APB only
// while no event is in flight.
`default_nettype none

module link_keepalive_supervisor
  import lks_pkg::*;
#(
  parameter int unsigned BURST_SLOTS = BURST_SLOTS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  lks_evt_if.sink                 evt,
  lks_rsp_if.source               rsp,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);

  cfg_t cfg;

  // Input register
  logic        in_valid;
  logic [1:0]  in_op;
  logic [31:0] in_now;
  logic [1:0]  in_kind;
  logic        in_crc_ok;
  logic [15:0] in_next_chunk;

  // Supervisor state
  logic        ping_pending, ping_pending_next;
  logic        update_mode, update_mode_next;
  logic [31:0] last_message_time, last_message_time_next;
  logic [31:0] last_chunk_time, last_chunk_time_next;
  logic [15:0] chunk_position, chunk_position_next;

  // Result register
  logic        rsp_valid;
  logic [2:0]  rsp_action, rsp_action_next;
  logic [15:0] rsp_index, rsp_index_next;

  logic        out_free;
  logic        fire;
  logic        evt_take;
  logic        burst_req;
  logic        too_soon;
  logic [31:0] gap_msg;
  logic [31:0] gap_chunk;

  lks_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Handshake: a word moves on when the result slot is free or draining
  assign out_free  = ~rsp_valid | rsp.ready;
  assign fire      = in_valid & out_free;
  assign evt.ready = ~in_valid | fire;
  assign evt_take  = evt.valid & evt.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (evt.ready) begin
      in_valid <= evt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (evt_take) begin
      in_op         <= evt.op;
      in_now        <= evt.now_ms;
      in_kind       <= evt.msg_kind;
      in_crc_ok     <= evt.crc_ok;
      in_next_chunk <= evt.next_chunk;
    end
  end

  // Burst history
  assign burst_req = fire & (in_op == OP_EVENT) & ~update_mode;

  lks_burst #(
    .BURST_SLOTS (BURST_SLOTS)
  ) u_burst (
    .clk       (clk),
    .rst       (rst),
    .req       (burst_req),
    .now_ms    (in_now),
    .window_ms (cfg.event_window_ms),
    .too_soon  (too_soon)
  );

  assign gap_msg   = in_now - last_message_time;
  assign gap_chunk = in_now - last_chunk_time;

  // Decision logic
  always_comb begin
    ping_pending_next      = ping_pending;
    update_mode_next       = update_mode;
    last_message_time_next = last_message_time;
    last_chunk_time_next   = last_chunk_time;
    chunk_position_next    = chunk_position;
    rsp_action_next        = ACT_NONE;
    rsp_index_next         = 16'd0;

    case (in_op)
      OP_TICK: begin
        if (update_mode) begin
          if (gap_chunk > {16'd0, cfg.chunk_timeout_ms}) begin
            rsp_action_next      = ACT_MISSED;
            rsp_index_next       = chunk_position;
            last_chunk_time_next = in_now;
          end
        end else if (ping_pending) begin
          if (gap_msg > {16'd0, cfg.ack_timeout_ms}) begin
            rsp_action_next        = ACT_DISCONNECT;
            ping_pending_next      = 1'b0;
            last_message_time_next = in_now;
          end
        end else if (gap_msg > {16'd0, cfg.ping_interval_ms}) begin
          rsp_action_next        = ACT_PING;
          ping_pending_next      = 1'b1;
          last_message_time_next = in_now;
        end
      end
      OP_MSG: begin
        last_message_time_next = in_now;
        ping_pending_next      = 1'b0;
        case (in_kind)
          KIND_BEGIN: begin
            last_chunk_time_next = in_now;
            chunk_position_next  = 16'd0;
            update_mode_next     = 1'b1;
          end
          KIND_CHUNK: begin
            last_chunk_time_next = in_now;
            if (!in_crc_ok) begin
              rsp_action_next = ACT_CHUNK_BAD;
            end else begin
              if (in_next_chunk > chunk_position) begin
                rsp_action_next = ACT_CHUNK_OK;
              end else begin
                rsp_action_next = ACT_MISSED;
                rsp_index_next  = in_next_chunk;
              end
              chunk_position_next = in_next_chunk;
            end
          end
          KIND_DONE: begin
            update_mode_next = 1'b0;
          end
          default: ;
        endcase
      end
      OP_EVENT: begin
        if (update_mode || too_soon) begin
          rsp_action_next = ACT_EVT_REFUSED;
        end else begin
          rsp_action_next = ACT_EVT_OK;
        end
      end
      default: begin
        update_mode_next = 1'b0;
      end
    endcase
  end

  // State update
  always_ff @(posedge clk) begin
    if (rst) begin
      ping_pending      <= 1'b0;
      update_mode       <= 1'b0;
      last_message_time <= 32'd0;
      last_chunk_time   <= 32'd0;
      chunk_position    <= 16'd0;
    end else if (fire) begin
      ping_pending      <= ping_pending_next;
      update_mode       <= update_mode_next;
      last_message_time <= last_message_time_next;
      last_chunk_time   <= last_chunk_time_next;
      chunk_position    <= chunk_position_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_free) begin
      rsp_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp_action <= rsp_action_next;
      rsp_index  <= rsp_index_next;
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.action       = rsp_action;
  assign rsp.missed_index = rsp_index;

endmodule

`default_nettype wire

FILE: hw/rtl/lks_cfg_regs.sv
// ----------------------------------------------------------------------------
// lks_cfg_regs
// APB register file holding the four 16-bit timing registers.
// ----------------------------------------------------------------------------
`default_nettype none

module lks_cfg_regs
  import lks_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  output cfg_t                    cfg
);

  logic                 wr_en;
  logic [CFG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[PADDR_W-1:2];

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.chunk_timeout_ms <= CHUNK_TIMEOUT_RST;
      cfg.ack_timeout_ms   <= ACK_TIMEOUT_RST;
      cfg.ping_interval_ms <= PING_INTERVAL_RST;
      cfg.event_window_ms  <= EVENT_WINDOW_RST;
    end else if (wr_en) begin
      case (idx)
        CFG_CHUNK_TIMEOUT: cfg.chunk_timeout_ms <= pwdata[15:0];
        CFG_ACK_TIMEOUT:   cfg.ack_timeout_ms   <= pwdata[15:0];
        CFG_PING_INTERVAL: cfg.ping_interval_ms <= pwdata[15:0];
        CFG_EVENT_WINDOW:  cfg.event_window_ms  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (idx)
      CFG_CHUNK_TIMEOUT: prdata = {16'd0, cfg.chunk_timeout_ms};
      CFG_ACK_TIMEOUT:   prdata = {16'd0, cfg.ack_timeout_ms};
      CFG_PING_INTERVAL: prdata = {16'd0, cfg.ping_interval_ms};
      CFG_EVENT_WINDOW:  prdata = {16'd0, cfg.event_window_ms};
      default:           prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/lks_burst.sv
// ----------------------------------------------------------------------------
// lks_burst
// Ring of recent event-request times; flags a request that completes a full
// burst inside the event window.
// ----------------------------------------------------------------------------
`default_nettype none

module lks_burst
  import lks_pkg::*;
#(
  parameter int unsigned BURST_SLOTS = BURST_SLOTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req,
  input  wire logic [31:0] now_ms,
  input  wire logic [15:0] window_ms,
  output logic             too_soon
);

  localparam int unsigned SLOT_W = $clog2(BURST_SLOTS);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(BURST_SLOTS - 1);

  logic [31:0]       history [BURST_SLOTS];
  logic [SLOT_W-1:0] slot;
  logic [SLOT_W-1:0] slot_next;
  logic [31:0]       age;

  // Write pointer advance with wrap
  assign slot_next = (slot == SLOT_LAST) ? '0 : slot + 1'b1;

  // The slot after the one written now holds the oldest stamp that this write keeps
  assign age      = now_ms - history[slot_next];
  assign too_soon = age < {16'd0, window_ms};

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
      for (int i = 0; i < BURST_SLOTS; i++) begin
        history[i] <= HISTORY_RST;
      end
    end else if (req) begin
      history[slot] <= now_ms;
      slot          <= slot_next;
    end
  end

endmodule

`default_nettype wire
